@@ rtl/avs_pkg.sv @@
// ----------------------------------------------------------------------------
// avs_pkg
// Shared types and constants of the voltmeter display scan driver.
// ----------------------------------------------------------------------------
package avs_pkg;

  // Converter and display geometry
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int FS_W            = 14;
  localparam int NUM_DIGITS      = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIGIT_IDX_W     = 2;

  localparam logic [FS_W-1:0] FS_RESET    = 14'd5000;
  localparam logic [FS_W-1:0] DISPLAY_MAX = 14'd9999;

  localparam logic [7:0] DP_MASK   = 8'h80;
  localparam logic [3:0] ALL_BLANK = 4'hF;

  // Request kinds carried through the queue
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [NUM_DIGITS-1:0] digits_t;

endpackage

@@ rtl/avs_if.sv @@
// ----------------------------------------------------------------------------
// avs_in_if / avs_out_if
// Valid/ready channels for incoming requests and outgoing display results.
// ----------------------------------------------------------------------------
interface avs_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface avs_out_if;
  logic       valid;
  logic       ready;
  logic       serial_data;
  logic       shift_pulse;
  logic       latch_pulse;
  logic [3:0] digit_enables;
  logic       last;

  modport source (output valid, output serial_data, output shift_pulse,
                  output latch_pulse, output digit_enables, output last,
                  input ready);
  modport sink   (input valid, input serial_data, input shift_pulse,
                  input latch_pulse, input digit_enables, input last,
                  output ready);
endinterface

@@ rtl/avs_fifo.sv @@
// ----------------------------------------------------------------------------
// avs_fifo
// Short register queue between the request front end and the executer.
// ----------------------------------------------------------------------------
module avs_fifo #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/avs_front.sv @@
// ----------------------------------------------------------------------------
// avs_front
// Accepts requests, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module avs_front #(
  parameter int SAMPLE_BITS = avs_pkg::SAMPLE_BITS_DEF
) (
  avs_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [SAMPLE_BITS:0] push_data_o
);
  import avs_pkg::*;

  op_e                    op;
  logic [SAMPLE_BITS-1:0] sample;

  // Take a request whenever the queue has room
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Classify: a tick carries no sample, a sample keeps its code
  always_comb begin
    if (in_i.cmd) begin
      op     = OP_TICK;
      sample = '0;
    end else begin
      op     = OP_SAMPLE;
      sample = in_i.sample;
    end
  end

  assign push_data_o = {op, sample};

endmodule

@@ rtl/avs_scale.sv @@
// ----------------------------------------------------------------------------
// avs_scale
// Scales a sample to millivolts, saturates, and splits it into the digit
// store. Holds the full-scale register.
// ----------------------------------------------------------------------------
module avs_scale #(
  parameter int SAMPLE_BITS = avs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [avs_pkg::FS_W-1:0] cfg_wdata_i,
  input  logic                    start_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    done_o,
  output avs_pkg::digits_t        digits_o
);
  import avs_pkg::*;

  localparam int PW = SAMPLE_BITS + FS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DIG  = 3'b100
  } scale_state_e;

  scale_state_e           state_q, state_d;
  logic [FS_W-1:0]        fs_q;
  logic [PW-1:0]          r_q, r_d;
  logic [FS_W:0]          quo_q, quo_d;
  logic [FS_W-1:0]        val_q, val_d;
  logic [DIGIT_IDX_W-1:0] idx_q, idx_d;
  digits_t                dig_q, dig_d;
  logic                   done_q, done_d;

  logic [FS_W-1:0]        hi;
  logic [SAMPLE_BITS-1:0] lo;
  logic [FS_W:0]          quo_fin;
  logic [3:0]             dgt;
  logic [FS_W-1:0]        sub;
  logic [FS_W-1:0]        thr;
  logic [FS_W-1:0]        rem;

  // k times the decimal place selected by idx
  function automatic logic [FS_W-1:0] place_mult(input logic [DIGIT_IDX_W-1:0] idx,
                                                 input int unsigned k);
    int unsigned p;
    case (idx)
      2'd0:    p = 1000;
      2'd1:    p = 100;
      default: p = 10;
    endcase
    return FS_W'(k * p);
  endfunction

  assign hi       = r_q[PW-1:SAMPLE_BITS];
  assign lo       = r_q[SAMPLE_BITS-1:0];
  assign quo_fin  = quo_q + {{FS_W{1'b0}}, (lo == {SAMPLE_BITS{1'b1}})};
  assign done_o   = done_q;
  assign digits_o = dig_q;

  // Pick the digit at the current place by parallel compares
  always_comb begin
    dgt = '0;
    sub = '0;
    thr = '0;
    for (int unsigned k = 1; k <= 9; k++) begin
      thr = place_mult(idx_q, k);
      if (val_q >= thr) begin
        dgt = 4'(k);
        sub = thr;
      end
    end
    rem = val_q - sub;
  end

  // Multiply, fold the division by the all-ones code, then peel digits
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    quo_d   = quo_q;
    val_d   = val_q;
    idx_d   = idx_q;
    dig_d   = dig_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          r_d     = PW'(sample_i) * PW'(fs_q);
          quo_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (hi != '0) begin
          quo_d = quo_q + {1'b0, hi};
          r_d   = PW'(hi) + PW'(lo);
        end else begin
          val_d   = (quo_fin > {1'b0, DISPLAY_MAX}) ? DISPLAY_MAX : quo_fin[FS_W-1:0];
          idx_d   = '0;
          state_d = S_DIG;
        end
      end
      S_DIG: begin
        dig_d[idx_q] = dgt;
        val_d        = rem;
        idx_d        = idx_q + 1'b1;
        if (idx_q == DIGIT_IDX_W'(NUM_DIGITS - 2)) begin
          dig_d[NUM_DIGITS-1] = rem[3:0];
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fs_q    <= FS_RESET;
      dig_q   <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        fs_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the working values
  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    quo_q <= quo_d;
    val_q <= val_d;
  end

endmodule

@@ rtl/avs_back.sv @@
// ----------------------------------------------------------------------------
// avs_back
// Executes queued requests: starts scaling for samples and streams the
// nine shift and latch results of a scan tick through an output register.
// ----------------------------------------------------------------------------
module avs_back #(
  parameter int SAMPLE_BITS = avs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [SAMPLE_BITS:0]   q_data_i,
  output logic                   q_pop_o,
  output logic                   scale_start_o,
  output logic [SAMPLE_BITS-1:0] scale_sample_o,
  input  logic                   scale_done_i,
  input  avs_pkg::digits_t       digits_i,
  avs_out_if.source              out_o
);
  import avs_pkg::*;

  localparam logic [3:0] LAST_CNT = 4'd8;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCALE = 3'b010,
    B_SHIFT = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [2:0]  scan_q, scan_d;
  logic [7:0]  seg_q, seg_d;
  logic [3:0]  en_q, en_d;
  logic [3:0]  cnt_q, cnt_d;

  logic        ovalid_q, ovalid_d;
  logic        osd_q, osd_d;
  logic        osh_q, osh_d;
  logic        ola_q, ola_d;
  logic [3:0]  oen_q, oen_d;
  logic        olast_q, olast_d;

  op_e                    op;
  logic                   out_free;
  logic                   take;
  logic [2:0]             pos_next;
  logic [1:0]             sel;
  logic [7:0]             seg_new;

  // Common-cathode segment pattern for one BCD digit
  function automatic logic [7:0] seg_of(input bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  assign op             = op_e'(q_data_i[SAMPLE_BITS]);
  assign scale_sample_o = q_data_i[SAMPLE_BITS-1:0];
  assign out_free       = !ovalid_q || out_o.ready;

  // Next scan position and its segment byte
  assign pos_next = (scan_q >= 3'd4) ? 3'd1 : scan_q + 3'd1;
  assign sel      = pos_next[1:0] - 2'd1;
  assign seg_new  = seg_of(digits_i[sel]) | ((pos_next == 3'd1) ? DP_MASK : 8'h00);

  // Take the next request when idle or while the final result is loaded
  assign take = q_valid_i &&
                ((state_q == B_IDLE) ||
                 ((state_q == B_SHIFT) && out_free && (cnt_q == LAST_CNT)));
  assign q_pop_o       = take;
  assign scale_start_o = take && (op == OP_SAMPLE);

  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    seg_d    = seg_q;
    en_d     = en_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_o.ready;
    osd_d    = osd_q;
    osh_d    = osh_q;
    ola_d    = ola_q;
    oen_d    = oen_q;
    olast_d  = olast_q;

    case (state_q)
      B_IDLE: begin
      end
      B_SCALE: begin
        if (scale_done_i) begin
          state_d = B_IDLE;
        end
      end
      B_SHIFT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (cnt_q == LAST_CNT) begin
            osd_d   = 1'b0;
            osh_d   = 1'b0;
            ola_d   = 1'b1;
            oen_d   = en_q;
            olast_d = 1'b1;
            state_d = B_IDLE;
          end else begin
            osd_d   = seg_q[7];
            osh_d   = 1'b1;
            ola_d   = 1'b0;
            oen_d   = ALL_BLANK;
            olast_d = 1'b0;
            seg_d   = {seg_q[6:0], 1'b0};
            cnt_d   = cnt_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    // Dispatch a newly popped request
    if (take) begin
      if (op == OP_SAMPLE) begin
        state_d = B_SCALE;
      end else begin
        state_d = B_SHIFT;
        scan_d  = pos_next;
        seg_d   = seg_new;
        en_d    = ALL_BLANK & ~(4'd1 << sel);
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      scan_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Hold segment byte, enable pattern and the result register
  always_ff @(posedge clk_i) begin
    seg_q   <= seg_d;
    en_q    <= en_d;
    osd_q   <= osd_d;
    osh_q   <= osh_d;
    ola_q   <= ola_d;
    oen_q   <= oen_d;
    olast_q <= olast_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.serial_data   = osd_q;
  assign out_o.shift_pulse   = osh_q;
  assign out_o.latch_pulse   = ola_q;
  assign out_o.digit_enables = oen_q;
  assign out_o.last          = olast_q;

endmodule

@@ rtl/adc_voltmeter_7seg_scan_driver.sv @@
// A tick's first result leaves the output register once the sequencer is in
// its shift state; its nine results follow one per cycle while the output is
// ready. The next request is taken while a tick's final result is loaded. A
// sample goes through a multiply step, fold steps, digit steps and a hand-back
// step before the next request is taken. Reset: asynchronous; digits zero,
// full scale 5000, scan position zero.
// ----------------------------------------------------------------------------
// adc_voltmeter_7seg_scan_driver
// Converter sample to four-digit display, with shift-register scan output.
// ----------------------------------------------------------------------------
module adc_voltmeter_7seg_scan_driver #(
  parameter int SAMPLE_BITS = avs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [avs_pkg::FS_W-1:0] cfg_wdata_i,
  avs_in_if.sink                   in_i,
  avs_out_if.source                out_o
);
  import avs_pkg::*;

  logic                   push;
  logic [SAMPLE_BITS:0]   push_data;
  logic                   full;
  logic                   pop;
  logic                   q_valid;
  logic [SAMPLE_BITS:0]   q_data;
  logic                   scale_start;
  logic [SAMPLE_BITS-1:0] scale_sample;
  logic                   scale_done;
  digits_t                digits;

  avs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  avs_fifo #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  avs_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (scale_start),
    .sample_i    (scale_sample),
    .done_o      (scale_done),
    .digits_o    (digits)
  );

  avs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (pop),
    .scale_start_o  (scale_start),
    .scale_sample_o (scale_sample),
    .scale_done_i   (scale_done),
    .digits_i       (digits),
    .out_o          (out_o)
  );

endmodule
